>>> design/assert_macros.svh
// Assertion helpers shared by the keyer modules.
// Each module that uses them has ports named clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define MCK_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every clock edge, during reset too.
`define MCK_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/mck_pkg.sv
package mck_pkg;

	// Register reset value and default queue depths.
	localparam logic [15:0] DOT_TIME_RESET = 16'd200;
	localparam int CMD_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;

	// ASCII codes used by the keyer.
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_DOT     = 8'h2E;
	localparam logic [7:0] CHAR_DASH    = 8'h2D;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_NONE    = 8'h00;

	// Gap that precedes a letter.
	localparam logic [1:0] GAP_NONE   = 2'd0;
	localparam logic [1:0] GAP_LETTER = 2'd1;
	localparam logic [1:0] GAP_WORD   = 2'd2;

	// Dot counts of the fixed segments.
	localparam logic [4:0] DOTS_LETTER_GAP = 5'd2;
	localparam logic [4:0] DOTS_WORD_GAP   = 5'd6;
	localparam logic [4:0] DOTS_SYMBOL_GAP = 5'd1;
	localparam logic [4:0] DOTS_NONE       = 5'd0;

	localparam int PAT_BITS = 16;
	localparam int DUR_WIDTH = 19;

	// One unit of work handed from the front end to the sequencer.
	typedef struct packed {
		logic [1:0] gap;
		logic       has_letter;
		logic [4:0] letter_idx;
		logic       eom;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic                 led_on;
		logic [DUR_WIDTH-1:0] duration_ticks;
		logic [7:0]           text_char;
		logic [1:0]           text_count;
		logic                 last_of_run;
	} res_t;

	// On/off pattern of each letter, walked from bit 15 down.
	function automatic logic [PAT_BITS-1:0] letter_pattern(input logic [4:0] idx);
		logic [PAT_BITS-1:0] pat;
		unique case (idx)
			5'd0:    pat = 16'hB800;
			5'd1:    pat = 16'hEA80;
			5'd2:    pat = 16'hEBA0;
			5'd3:    pat = 16'hEA00;
			5'd4:    pat = 16'h8000;
			5'd5:    pat = 16'hAE80;
			5'd6:    pat = 16'hEE80;
			5'd7:    pat = 16'hAA00;
			5'd8:    pat = 16'hA000;
			5'd9:    pat = 16'hBBB8;
			5'd10:   pat = 16'hEB80;
			5'd11:   pat = 16'hBA80;
			5'd12:   pat = 16'hEE00;
			5'd13:   pat = 16'hE800;
			5'd14:   pat = 16'hEEE0;
			5'd15:   pat = 16'hBBA0;
			5'd16:   pat = 16'hEEB8;
			5'd17:   pat = 16'hBA00;
			5'd18:   pat = 16'hA800;
			5'd19:   pat = 16'hE000;
			5'd20:   pat = 16'hAE00;
			5'd21:   pat = 16'hAB80;
			5'd22:   pat = 16'hBB80;
			5'd23:   pat = 16'hEAE0;
			5'd24:   pat = 16'hEBB8;
			5'd25:   pat = 16'hEEA0;
			default: pat = '0;
		endcase
		return pat;
	endfunction

endpackage

>>> design/mck_fifo.sv
`include "assert_macros.svh"

module mck_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	// Status and head of queue.
	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	// Storage, written at the tail.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// The count never exceeds the depth.
	`MCK_ASSERT(a_count_bound, count_q <= CNT_FULL, "fifo count above depth")
	// A write to a full queue would be lost.
	`MCK_ASSERT(a_no_overflow, !(wr && full), "write to full fifo")
	// The count rises by one after a write without a read.
	`MCK_ASSERT(a_count_track, (do_wr && !do_rd) |=> (count_q == $past(count_q) + CNT_W'(1)), "fifo count did not advance on write")

endmodule

>>> design/mck_front.sv
module mck_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    char_code,
	input  logic          end_of_message,
	input  logic          cmd_full,
	output logic          cmd_wr,
	output mck_pkg::cmd_t cmd
);

	logic       message_started_q;
	logic       word_gap_pending_q;
	logic       accept;
	logic       is_upper;
	logic       is_lower;
	logic       is_letter;
	logic       is_space;
	logic [7:0] letter_off;

	// Classify the incoming byte.
	always_comb begin
		is_upper   = (char_code >= mck_pkg::CHAR_UPPER_A) && (char_code <= mck_pkg::CHAR_UPPER_Z);
		is_lower   = (char_code >= mck_pkg::CHAR_LOWER_A) && (char_code <= mck_pkg::CHAR_LOWER_Z);
		is_letter  = is_upper || is_lower;
		is_space   = (char_code == mck_pkg::CHAR_SPACE);
		letter_off = is_upper ? (char_code - mck_pkg::CHAR_UPPER_A)
			: (char_code - mck_pkg::CHAR_LOWER_A);
	end

	// Accept whenever the command queue has room.
	assign full   = cmd_full;
	assign accept = push && !cmd_full;
	assign cmd_wr = accept && (is_letter || end_of_message);

	// Build the command: which gap comes first, the letter, and the newline flag.
	// A command without a letter carries no gap.
	always_comb begin
		cmd.has_letter = is_letter;
		cmd.letter_idx = letter_off[4:0];
		cmd.eom        = end_of_message;
		if (!is_letter || !message_started_q) begin
			cmd.gap = mck_pkg::GAP_NONE;
		end else if (word_gap_pending_q) begin
			cmd.gap = mck_pkg::GAP_WORD;
		end else begin
			cmd.gap = mck_pkg::GAP_LETTER;
		end
	end

	// Message state, updated per accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			message_started_q  <= 1'b0;
			word_gap_pending_q <= 1'b0;
		end else if (accept) begin
			if (end_of_message) begin
				message_started_q  <= 1'b0;
				word_gap_pending_q <= 1'b0;
			end else if (is_letter) begin
				message_started_q  <= 1'b1;
				word_gap_pending_q <= 1'b0;
			end else if (is_space && message_started_q) begin
				word_gap_pending_q <= 1'b1;
			end
		end
	end

endmodule

>>> design/mck_back.sv
`include "assert_macros.svh"

module mck_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   dot_time,
	input  logic          cmd_empty,
	input  mck_pkg::cmd_t cmd,
	output logic          cmd_rd,
	input  logic          res_full,
	output logic          res_wr,
	output mck_pkg::res_t res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GAP  = 3'd1;
	localparam logic [2:0] ST_BITS = 3'd2;
	localparam logic [2:0] ST_OFF  = 3'd3;
	localparam logic [2:0] ST_NL   = 3'd4;

	localparam logic [4:0] REM_FULL = 5'(mck_pkg::PAT_BITS);

	logic [2:0]          state_q;
	mck_pkg::cmd_t       cmd_q;
	logic [15:0]         pat_q;
	logic [4:0]          rem_q;
	logic [4:0]          ones_q;
	logic                prevz_q;
	logic [3:0]          bit_idx;
	logic                cur_bit;
	logic                walk_end;
	logic [4:0]          dots;
	logic [20:0]         product;
	logic [2:0]          after_walk;

	// Current bit of the pattern and the end-of-letter test after an off segment.
	always_comb begin
		bit_idx    = rem_q[3:0] - 4'd1;
		cur_bit    = pat_q[bit_idx];
		walk_end   = (rem_q == 5'd1) || !pat_q[bit_idx - 4'd1];
		after_walk = cmd_q.eom ? ST_NL : ST_IDLE;
	end

	// Result transaction of the current step and its length in ticks.
	always_comb begin
		cmd_rd          = 1'b0;
		res_wr          = 1'b0;
		res.led_on      = 1'b0;
		res.text_char   = mck_pkg::CHAR_NONE;
		res.text_count  = 2'd0;
		res.last_of_run = 1'b0;
		dots            = mck_pkg::DOTS_NONE;
		unique case (state_q)
			ST_IDLE: begin
				cmd_rd = !cmd_empty;
			end
			ST_GAP: begin
				res_wr        = !res_full;
				res.text_char = mck_pkg::CHAR_SPACE;
				if (cmd_q.gap == mck_pkg::GAP_WORD) begin
					dots           = mck_pkg::DOTS_WORD_GAP;
					res.text_count = 2'd3;
				end else begin
					dots           = mck_pkg::DOTS_LETTER_GAP;
					res.text_count = 2'd1;
				end
			end
			ST_BITS: begin
				res_wr     = !res_full && (rem_q != 5'd0) && !cur_bit && !prevz_q;
				res.led_on = 1'b1;
				dots       = ones_q;
				if (ones_q == 5'd1) begin
					res.text_char  = mck_pkg::CHAR_DOT;
					res.text_count = 2'd1;
				end else if (ones_q == 5'd3) begin
					res.text_char  = mck_pkg::CHAR_DASH;
					res.text_count = 2'd1;
				end
			end
			ST_OFF: begin
				res_wr          = !res_full;
				dots            = mck_pkg::DOTS_SYMBOL_GAP;
				res.last_of_run = walk_end && !cmd_q.eom;
			end
			ST_NL: begin
				res_wr          = !res_full;
				res.text_char   = mck_pkg::CHAR_NEWLINE;
				res.text_count  = 2'd1;
				res.last_of_run = 1'b1;
			end
			default: begin
				cmd_rd = 1'b0;
			end
		endcase
		product            = 21'(dot_time) * 21'(dots);
		res.duration_ticks = product[mck_pkg::DUR_WIDTH-1:0];
	end

	// Command payload and pattern.
	always_ff @(posedge clk) begin
		if (cmd_rd) begin
			cmd_q <= cmd;
			pat_q <= mck_pkg::letter_pattern(cmd.letter_idx);
		end
	end

	// Sequencer: the gap if any, then the pattern walk, then the newline at end of message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
			ones_q  <= '0;
			prevz_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_rd) begin
						rem_q   <= REM_FULL;
						ones_q  <= '0;
						prevz_q <= 1'b0;
						if (cmd.gap != mck_pkg::GAP_NONE) begin
							state_q <= ST_GAP;
						end else if (cmd.has_letter) begin
							state_q <= ST_BITS;
						end else begin
							state_q <= ST_NL;
						end
					end
				end
				ST_GAP: begin
					if (!res_full) begin
						state_q <= ST_BITS;
					end
				end
				ST_BITS: begin
					if (rem_q == 5'd0) begin
						state_q <= after_walk;
					end else if (cur_bit) begin
						ones_q  <= ones_q + 5'd1;
						rem_q   <= rem_q - 5'd1;
						prevz_q <= 1'b0;
					end else if (prevz_q) begin
						state_q <= after_walk;
					end else if (!res_full) begin
						state_q <= ST_OFF;
					end
				end
				ST_OFF: begin
					if (!res_full) begin
						ones_q  <= '0;
						prevz_q <= 1'b1;
						rem_q   <= rem_q - 5'd1;
						state_q <= walk_end ? after_walk : ST_BITS;
					end
				end
				ST_NL: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A new command is taken only between commands.
	`MCK_ASSERT(a_rd_idle, cmd_rd |-> (state_q == ST_IDLE), "command taken mid-sequence")
	// The newline always closes the run.
	`MCK_ASSERT(a_nl_last, (res_wr && (state_q == ST_NL)) |-> res.last_of_run, "newline not marked last")
	// After the last transaction of a run the sequencer is idle.
	`MCK_ASSERT(a_last_idle, (res_wr && res.last_of_run) |=> (state_q == ST_IDLE), "sequencer busy after last transaction")

endmodule

>>> design/morse_code_keyer.sv
// Morse code keyer.
// Input channel: push with char_code and end_of_message; an item is taken
// at a clock edge with push high and full low. Letters of either case are
// keyed, a space marks a word break, other bytes are dropped; end_of_message
// adds a newline transaction and ends the message.
// Result channel: while empty is low the oldest result is on led_on,
// duration_ticks, text_char, text_count and last_of_run; pop high takes it.
// Configuration: dot_time_wr high writes dot_time, the dot length in ticks.
// The front end classifies bytes and queues commands (four deep by default);
// the sequencer walks the letter pattern bit by bit, takes a new command only
// once the last is done, and writes results into a two-deep output queue.
// Per letter the sequencer takes the command, writes the gap if any, walks
// the pattern bits and follows each on segment with an off segment; a
// newline adds a step of its own; dropped bytes cost the sequencer nothing.
// A stalled receiver fills the output queue, then the sequencer waits, then
// the command queue fills and full rises; nothing is dropped.
// Reset clears both queues and the message state and sets dot_time to 200.
module morse_code_keyer #(
	parameter int CMD_DEPTH = mck_pkg::CMD_DEPTH_DEF,
	parameter int OUT_DEPTH = mck_pkg::OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic        end_of_message,
	output logic        empty,
	input  logic        pop,
	output logic        led_on,
	output logic [18:0] duration_ticks,
	output logic [7:0]  text_char,
	output logic [1:0]  text_count,
	output logic        last_of_run,
	input  logic        dot_time_wr,
	input  logic [15:0] dot_time
);

	logic [15:0]   dot_time_q;
	logic          cmd_wr;
	logic          cmd_full;
	logic          cmd_empty;
	logic          cmd_rd;
	mck_pkg::cmd_t cmd_in;
	mck_pkg::cmd_t cmd_out;
	logic          res_wr;
	logic          res_full;
	mck_pkg::res_t res_in;
	mck_pkg::res_t res_out;

	// Dot time register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_time_q <= mck_pkg::DOT_TIME_RESET;
		end else if (dot_time_wr) begin
			dot_time_q <= dot_time;
		end
	end

	// Front end: accepts and classifies bytes.
	mck_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.char_code      (char_code),
		.end_of_message (end_of_message),
		.cmd_full       (cmd_full),
		.cmd_wr         (cmd_wr),
		.cmd            (cmd_in)
	);

	// Command queue between front end and sequencer.
	mck_fifo #(
		.WIDTH ($bits(mck_pkg::cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.rd     (cmd_rd),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	// Sequencer: turns commands into timed segments.
	mck_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dot_time  (dot_time_q),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_rd    (cmd_rd),
		.res_full  (res_full),
		.res_wr    (res_wr),
		.res       (res_in)
	);

	// Result queue toward the receiver.
	mck_fifo #(
		.WIDTH ($bits(mck_pkg::res_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res_in),
		.full   (res_full),
		.rd     (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	// Result fields.
	assign led_on         = res_out.led_on;
	assign duration_ticks = res_out.duration_ticks;
	assign text_char      = res_out.text_char;
	assign text_count     = res_out.text_count;
	assign last_of_run    = res_out.last_of_run;

endmodule
